// File: rtl/core/spc3_pkg.sv
`default_nettype none

package spc3_pkg;

  // parameter defaults
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned MAX_IN_CH_DEF  = 16;
  localparam int unsigned MAX_OUT_CH_DEF = 16;
  localparam int unsigned MAX_KERNEL_DEF = 3;
  localparam int unsigned COORD_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 5;

  // command codes
  typedef enum logic [2:0] {
    CMD_LOAD_COORD = 3'd0,
    CMD_LOAD_FEAT  = 3'd1,
    CMD_LOAD_WT    = 3'd2,
    CMD_PAIR       = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CH  = 3'd0,
    REG_OUT_CH = 3'd1,
    REG_KER_X  = 3'd2,
    REG_KER_Y  = 3'd3,
    REG_KER_Z  = 3'd4
  } cfg_idx_e;

  localparam logic [4:0] RST_IN_CH  = 5'd16;
  localparam logic [4:0] RST_OUT_CH = 5'd16;
  localparam logic [1:0] RST_KER    = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [9:0]         point_index;
    logic [9:0]         partner_index;
    logic [15:0]        coord_x;
    logic [15:0]        coord_y;
    logic [15:0]        coord_z;
    logic [1:0]         tap_x;
    logic [1:0]         tap_y;
    logic [1:0]         tap_z;
    logic [3:0]         in_channel;
    logic [3:0]         out_channel;
    logic signed [15:0] sample_value;
  } item_t;

  typedef struct packed {
    logic [9:0]               point_index_out;
    logic [3:0]               out_channel_index;
    logic signed [ACC_W-1:0]  accum_value;
    logic                     last;
    logic                     offset_error;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic coord_we;
    logic feat_we;
    logic wt_we;
    logic coord_rd;
    logic offs_en;
    logic row_rd;
    logic dir;
    logic issue;
    logic emit;
    logic last;
    logic clr_we;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       pa_ok;
    logic       pb_ok;
    logic       same;
    logic       ofs_ok;
    logic       pipe_busy;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/spc3_ctrl.sv
`default_nettype none

module spc3_ctrl #(
  parameter int unsigned MAX_POINTS = spc3_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_OUT_CH = spc3_pkg::MAX_OUT_CH_DEF,
  localparam int unsigned PTW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [4:0]         nout_i,
  input  wire spc3_pkg::status_t  st_i,
  output spc3_pkg::ctrl_t         cmd_o,
  output logic [OCW-1:0]          chan_o,
  output logic [PTW-1:0]          sweep_o,
  output logic                    busy_o
);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_DISP  = 10'b0000000100,
    ST_COORD = 10'b0000001000,
    ST_OFFS  = 10'b0000010000,
    ST_CHK   = 10'b0000100000,
    ST_RUN   = 10'b0001000000,
    ST_DRAIN = 10'b0010000000,
    ST_RDROW = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_e;

  state_e         state_q, state_d;
  logic [OCW-1:0] chan_q, chan_d;
  logic [PTW-1:0] sweep_q, sweep_d;
  logic           dir_q, dir_d;
  logic           chan_last;
  logic           second_dir;

  assign chan_last  = (32'(chan_q) + 32'd1) == 32'(nout_i);
  assign second_dir = !dir_q && !st_i.same;

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    sweep_d = sweep_q;
    dir_d   = dir_q;
    cmd_o   = '0;
    cmd_o.dir = dir_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sweep_q == PTW'(MAX_POINTS - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        dir_d   = 1'b0;
        state_d = ST_IDLE;
        case (st_i.cmd)
          spc3_pkg::CMD_LOAD_COORD: cmd_o.coord_we = 1'b1;
          spc3_pkg::CMD_LOAD_FEAT:  cmd_o.feat_we  = 1'b1;
          spc3_pkg::CMD_LOAD_WT:    cmd_o.wt_we    = 1'b1;
          spc3_pkg::CMD_PAIR: begin
            if (st_i.pa_ok && st_i.pb_ok) begin
              state_d = ST_COORD;
            end
          end
          spc3_pkg::CMD_READ: begin
            if (st_i.pa_ok) begin
              state_d = ST_RDROW;
            end
          end
          spc3_pkg::CMD_CLEAR: state_d = ST_CLEAR;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_COORD: begin
        cmd_o.coord_rd = 1'b1;
        state_d        = ST_OFFS;
      end
      ST_OFFS: begin
        cmd_o.offs_en = 1'b1;
        cmd_o.row_rd  = 1'b1;
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        chan_d = '0;
        if (st_i.ofs_ok) begin
          state_d = ST_RUN;
        end else if (second_dir) begin
          dir_d   = 1'b1;
          state_d = ST_OFFS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (chan_last) begin
          state_d = ST_DRAIN;
        end else begin
          chan_d = chan_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!st_i.pipe_busy) begin
          if (second_dir) begin
            dir_d   = 1'b1;
            state_d = ST_OFFS;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RDROW: begin
        cmd_o.row_rd = 1'b1;
        chan_d       = '0;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = chan_last;
        if (chan_last) begin
          state_d = ST_IDLE;
        end else begin
          chan_d = chan_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      chan_q  <= '0;
      sweep_q <= '0;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      sweep_q <= sweep_d;
      dir_q   <= dir_d;
    end
  end

  assign chan_o  = chan_q;
  assign sweep_o = sweep_q;
  assign busy_o  = (state_q != ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !st_i.pipe_busy)
    else $error("idle with accumulate pipeline still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == ST_IDLE)
    else $error("read run did not end after last channel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_we |-> !st_i.pipe_busy)
    else $error("clear sweep overlaps accumulate writes");

endmodule

`default_nettype wire

// File: rtl/core/spc3_datapath.sv
`default_nettype none

module spc3_datapath #(
  parameter int unsigned MAX_POINTS = spc3_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_IN_CH  = spc3_pkg::MAX_IN_CH_DEF,
  parameter int unsigned MAX_OUT_CH = spc3_pkg::MAX_OUT_CH_DEF,
  parameter int unsigned MAX_KERNEL = spc3_pkg::MAX_KERNEL_DEF,
  parameter int unsigned COORD_BITS = spc3_pkg::COORD_BITS_DEF,
  localparam int unsigned PTW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_we_i,
  input  wire spc3_pkg::item_t    item_i,
  input  wire logic [4:0]         nin_i,
  input  wire logic [4:0]         nout_i,
  input  wire logic [1:0]         kx_i,
  input  wire logic [1:0]         ky_i,
  input  wire logic [1:0]         kz_i,
  input  wire spc3_pkg::ctrl_t    cmd_i,
  input  wire logic [OCW-1:0]     chan_i,
  input  wire logic [PTW-1:0]     sweep_i,
  output spc3_pkg::status_t       st_o,
  output spc3_pkg::result_t       result_o
);

  localparam int unsigned ACC_W = spc3_pkg::ACC_W;
  localparam int unsigned ICW   = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int unsigned KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned WROWS = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL * MAX_OUT_CH;
  localparam int unsigned WAW   = (WROWS > 1) ? $clog2(WROWS) : 1;
  localparam int unsigned NG    = (MAX_IN_CH + 3) / 4;
  localparam int unsigned GW    = 34;
  localparam int unsigned SUMW  = GW + ((NG > 1) ? $clog2(NG) : 0) + 1;
  localparam int unsigned OW    = COORD_BITS + 2;
  localparam logic signed [ACC_W+1:0] SAT_HI = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W+1:0] SAT_LO = {3'b111, {(ACC_W-1){1'b0}}};

  function automatic logic [WAW-1:0] wt_row(input logic [KW-1:0] tx, input logic [KW-1:0] ty,
                                            input logic [KW-1:0] tz, input logic [OCW-1:0] oc);
    wt_row = ((WAW'(tx) * WAW'(MAX_KERNEL) + WAW'(ty)) * WAW'(MAX_KERNEL) + WAW'(tz))
             * WAW'(MAX_OUT_CH) + WAW'(oc);
  endfunction

  // stores
  logic [3*COORD_BITS-1:0]  coord_mem [MAX_POINTS];
  logic signed [15:0]       feat_mem  [MAX_POINTS][MAX_IN_CH];
  logic signed [15:0]       wt_mem    [WROWS][MAX_IN_CH];
  logic signed [ACC_W-1:0]  acc_mem   [MAX_POINTS][MAX_OUT_CH];

  spc3_pkg::item_t          item_q;
  logic [3*COORD_BITS-1:0]  coord_p_q, coord_r_q;
  logic signed [15:0]       frow_q [MAX_IN_CH];
  logic signed [15:0]       wrow_q [MAX_IN_CH];
  logic signed [ACC_W-1:0]  accrow_q [MAX_OUT_CH];
  logic                     ok_q, err_q;
  logic [KW-1:0]            tap_q [3];

  logic                     v0_q, v1_q, v2_q, v3_q;
  logic [OCW-1:0]           j0_q, j1_q, j2_q, j3_q;
  logic signed [31:0]       prod_q [MAX_IN_CH];
  logic signed [GW-1:0]     grp_d [NG];
  logic signed [GW-1:0]     grp_q [NG];
  logic signed [SUMW-1:0]   sum_d, sum_q;
  logic signed [ACC_W+1:0]  total;
  logic signed [ACC_W-1:0]  acc_new;

  logic                     pa_ok, pb_ok, feat_ok, wt_ok;
  logic [PTW-1:0]           pa_idx, pb_idx, a_idx, b_idx;
  logic [COORD_BITS-1:0]    ca [3];
  logic [COORD_BITS-1:0]    cb [3];
  logic [1:0]               ks [3];
  logic signed [OW-1:0]     diff [3];
  logic [2:0]               ax_ok;
  logic [KW-1:0]            tap_d [3];

  always_ff @(posedge clk_i) begin
    if (item_we_i) begin
      item_q <= item_i;
    end
  end

  // index checks
  assign pa_ok   = 32'(item_q.point_index) < MAX_POINTS;
  assign pb_ok   = 32'(item_q.partner_index) < MAX_POINTS;
  assign feat_ok = pa_ok && (32'(item_q.in_channel) < MAX_IN_CH);
  assign wt_ok   = (32'(item_q.tap_x) < MAX_KERNEL) && (32'(item_q.tap_y) < MAX_KERNEL)
                && (32'(item_q.tap_z) < MAX_KERNEL) && (32'(item_q.in_channel) < MAX_IN_CH)
                && (32'(item_q.out_channel) < MAX_OUT_CH);
  assign pa_idx  = PTW'(item_q.point_index);
  assign pb_idx  = PTW'(item_q.partner_index);
  assign a_idx   = cmd_i.dir ? pb_idx : pa_idx;
  assign b_idx   = cmd_i.dir ? pa_idx : pb_idx;

  // coordinate store, two read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_we && pa_ok) begin
      coord_mem[pa_idx] <= {COORD_BITS'(item_q.coord_z), COORD_BITS'(item_q.coord_y),
                            COORD_BITS'(item_q.coord_x)};
    end
    if (cmd_i.coord_rd) begin
      coord_p_q <= coord_mem[pa_idx];
      coord_r_q <= coord_mem[pb_idx];
    end
  end

  // feature store, one lane written, whole row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_we && feat_ok) begin
      feat_mem[pa_idx][ICW'(item_q.in_channel)] <= item_q.sample_value;
    end
    if (cmd_i.row_rd) begin
      frow_q <= feat_mem[b_idx];
    end
  end

  // weight store, row per tap and output channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_we && wt_ok) begin
      wt_mem[wt_row(KW'(item_q.tap_x), KW'(item_q.tap_y), KW'(item_q.tap_z),
                    OCW'(item_q.out_channel))][ICW'(item_q.in_channel)] <= item_q.sample_value;
    end
    if (cmd_i.issue) begin
      wrow_q <= wt_mem[wt_row(tap_q[0], tap_q[1], tap_q[2], chan_i)];
    end
  end

  // tap offsets for the current direction
  assign ks[0] = kx_i;
  assign ks[1] = ky_i;
  assign ks[2] = kz_i;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      ca[x] = cmd_i.dir ? coord_r_q[x*COORD_BITS +: COORD_BITS]
                        : coord_p_q[x*COORD_BITS +: COORD_BITS];
      cb[x] = cmd_i.dir ? coord_p_q[x*COORD_BITS +: COORD_BITS]
                        : coord_r_q[x*COORD_BITS +: COORD_BITS];
      diff[x] = $signed({2'b00, cb[x]}) - $signed({2'b00, ca[x]})
              + $signed(OW'(ks[x] >> 1));
      ax_ok[x] = !diff[x][OW-1] && (diff[x] < $signed(OW'(ks[x])));
      tap_d[x] = KW'(diff[x]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.offs_en) begin
      ok_q  <= &ax_ok;
      tap_q <= tap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (cmd_i.offs_en && !(&ax_ok)) begin
      err_q <= 1'b1;
    end
  end

  // multiply-accumulate pipeline: weight read, products, group sums, total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    j0_q <= chan_i;
    j1_q <= j0_q;
    j2_q <= j1_q;
    j3_q <= j2_q;
    for (int k = 0; k < MAX_IN_CH; k++) begin
      prod_q[k] <= (32'(k) < 32'(nin_i)) ? frow_q[k] * wrow_q[k] : 32'sd0;
    end
    grp_q <= grp_d;
    sum_q <= sum_d;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (g * 4 + i < MAX_IN_CH) begin
          grp_d[g] = grp_d[g] + GW'(prod_q[g*4+i]);
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NG; g++) begin
      sum_d = sum_d + SUMW'(grp_q[g]);
    end
  end

  assign total = (ACC_W+2)'(accrow_q[j3_q]) + (ACC_W+2)'(sum_q);

  always_comb begin
    if (total > SAT_HI) begin
      acc_new = SAT_HI[ACC_W-1:0];
    end else if (total < SAT_LO) begin
      acc_new = SAT_LO[ACC_W-1:0];
    end else begin
      acc_new = total[ACC_W-1:0];
    end
  end

  // accumulator store: row sweep for clear, lane write, row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      for (int l = 0; l < MAX_OUT_CH; l++) begin
        acc_mem[sweep_i][l] <= '0;
      end
    end else if (v3_q) begin
      acc_mem[a_idx][j3_q] <= acc_new;
    end
    if (cmd_i.row_rd) begin
      accrow_q <= acc_mem[a_idx];
    end
  end

  always_comb begin
    st_o           = '0;
    st_o.cmd       = item_q.cmd;
    st_o.pa_ok     = pa_ok;
    st_o.pb_ok     = pb_ok;
    st_o.same      = (item_q.point_index == item_q.partner_index);
    st_o.ofs_ok    = ok_q;
    st_o.pipe_busy = v0_q | v1_q | v2_q | v3_q;
  end

  always_comb begin
    result_o                   = '0;
    result_o.point_index_out   = item_q.point_index;
    result_o.out_channel_index = 4'(chan_i);
    result_o.accum_value       = accrow_q[chan_i];
    result_o.last              = cmd_i.last;
    result_o.offset_error      = err_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(err_q))
    else $error("offset error flag dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (32'(j3_q) < 32'(nout_i)))
    else $error("accumulate write to channel beyond count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> ok_q)
    else $error("channel issued for an out-of-kernel offset");

endmodule

`default_nettype wire

// File: rtl/core/sparse_conv3d_pair_mac.sv
`default_nettype none

// sparse 3d convolution over a pair list, fixed point multiply-accumulate
//
// input channel: an item transfers at a rising edge with start high and busy
//   low; busy stays high until the item is completely done
// cmd load coords / load feature / load weight: written in the dispatch state
// cmd pair: dispatch and coordinate read, then per direction the offset
//   computation and offset check, one issue per output channel and a drain
//   of the accumulate pipeline; both directions when the points differ;
//   a direction off the kernel ends after its offset check; each output
//   channel reads one weight row feeding a 16-lane product, a two-level adder
//   tree and the saturating add into the accumulator row
// cmd read: results follow the dispatch and row read states, one output
//   channel per cycle on result_valid_o, last marks the final channel
// cmd clear and reset: a clearing pass writes one accumulator row per cycle,
//   covering all MAX_POINTS rows (1024 by default), busy high throughout
// results show for exactly one cycle; the receiver cannot stall them
// config channel: cfg_ready_o is always high, write only while busy is low

module sparse_conv3d_pair_mac #(
  parameter int unsigned MAX_POINTS = spc3_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_IN_CH  = spc3_pkg::MAX_IN_CH_DEF,
  parameter int unsigned MAX_OUT_CH = spc3_pkg::MAX_OUT_CH_DEF,
  parameter int unsigned MAX_KERNEL = spc3_pkg::MAX_KERNEL_DEF,
  parameter int unsigned COORD_BITS = spc3_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire spc3_pkg::item_t                   item_i,
  output logic                                   result_valid_o,
  output spc3_pkg::result_t                      result_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [spc3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [spc3_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int unsigned PTW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;

  // configuration registers
  logic [4:0] in_ch_q, out_ch_q;
  logic [1:0] ker_x_q, ker_y_q, ker_z_q;
  logic [4:0] nin, nout;
  logic [1:0] kx, ky, kz;

  spc3_pkg::ctrl_t   ctrl;
  spc3_pkg::status_t stat;
  logic [OCW-1:0]    chan;
  logic [PTW-1:0]    sweep;
  logic              accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= spc3_pkg::RST_IN_CH;
      out_ch_q <= spc3_pkg::RST_OUT_CH;
      ker_x_q  <= spc3_pkg::RST_KER;
      ker_y_q  <= spc3_pkg::RST_KER;
      ker_z_q  <= spc3_pkg::RST_KER;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spc3_pkg::REG_IN_CH:  in_ch_q  <= cfg_data_i;
        spc3_pkg::REG_OUT_CH: out_ch_q <= cfg_data_i;
        spc3_pkg::REG_KER_X:  ker_x_q  <= cfg_data_i[1:0];
        spc3_pkg::REG_KER_Y:  ker_y_q  <= cfg_data_i[1:0];
        spc3_pkg::REG_KER_Z:  ker_z_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // effective values, zero lifts to one and oversize drops to the maximum
  assign nin  = (in_ch_q == 5'd0) ? 5'd1
              : (32'(in_ch_q) > MAX_IN_CH) ? 5'(MAX_IN_CH) : in_ch_q;
  assign nout = (out_ch_q == 5'd0) ? 5'd1
              : (32'(out_ch_q) > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : out_ch_q;
  assign kx   = (ker_x_q == 2'd0) ? 2'd1
              : (32'(ker_x_q) > MAX_KERNEL) ? 2'(MAX_KERNEL) : ker_x_q;
  assign ky   = (ker_y_q == 2'd0) ? 2'd1
              : (32'(ker_y_q) > MAX_KERNEL) ? 2'(MAX_KERNEL) : ker_y_q;
  assign kz   = (ker_z_q == 2'd0) ? 2'd1
              : (32'(ker_z_q) > MAX_KERNEL) ? 2'(MAX_KERNEL) : ker_z_q;

  // item transfer
  assign accept = start && !busy;

  spc3_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_OUT_CH (MAX_OUT_CH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .nout_i  (nout),
    .st_i    (stat),
    .cmd_o   (ctrl),
    .chan_o  (chan),
    .sweep_o (sweep),
    .busy_o  (busy)
  );

  spc3_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_IN_CH  (MAX_IN_CH),
    .MAX_OUT_CH (MAX_OUT_CH),
    .MAX_KERNEL (MAX_KERNEL),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_we_i (accept),
    .item_i    (item_i),
    .nin_i     (nin),
    .nout_i    (nout),
    .kx_i      (kx),
    .ky_i      (ky),
    .kz_i      (kz),
    .cmd_i     (ctrl),
    .chan_i    (chan),
    .sweep_i   (sweep),
    .st_o      (stat),
    .result_o  (result_o)
  );

  // one result per cycle of the read run
  assign result_valid_o = ctrl.emit;

endmodule

`default_nettype wire
